// ===== src/dsf_pkg.sv =====
// shared types, widths and register codes for the damped spring force block
package dsf_pkg;

    localparam int CoordW   = 32;          // signed q16.16 coordinate
    localparam int DiffW    = 33;          // coordinate difference
    localparam int SqW      = 2 * DiffW;   // squared difference
    localparam int LenW     = 34;          // spring length
    localparam int RadW     = 2 * LenW;    // padded radicand
    localparam int RemW     = LenW + 1;    // square root remainder
    localparam int QuotW    = 31;          // unit vector magnitude, q1.30
    localparam int CfgW     = 31;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 32;

    localparam logic [CfgW-1:0] STIFFNESS_RESET = 31'd65536;
    localparam logic [CfgW-1:0] DAMPING_RESET   = 31'd0;
    localparam logic [CfgW-1:0] REST_LEN_RESET  = 31'd65536;

    typedef enum logic [CfgIdxW-1:0] {
        REG_STIFFNESS = 2'd0,
        REG_DAMPING   = 2'd1,
        REG_REST_LEN  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_a_x;
        logic signed [CoordW-1:0] pos_a_y;
        logic signed [CoordW-1:0] pos_a_z;
        logic signed [CoordW-1:0] pos_b_x;
        logic signed [CoordW-1:0] pos_b_y;
        logic signed [CoordW-1:0] pos_b_z;
        logic signed [CoordW-1:0] vel_a_x;
        logic signed [CoordW-1:0] vel_a_y;
        logic signed [CoordW-1:0] vel_a_z;
        logic signed [CoordW-1:0] vel_b_x;
        logic signed [CoordW-1:0] vel_b_y;
        logic signed [CoordW-1:0] vel_b_z;
    } item_t;

    typedef struct packed {
        logic signed [CoordW-1:0] force_x;
        logic signed [CoordW-1:0] force_y;
        logic signed [CoordW-1:0] force_z;
        logic                     zero_length;
        logic                     clipped;
    } result_t;

    // carried alongside the square root
    typedef struct packed {
        logic [2:0][DiffW-1:0] d_mag;
        logic [2:0]            d_neg;
        logic [2:0][DiffW-1:0] dv;
    } sqrt_side_t;

    // carried alongside the divider
    typedef struct packed {
        logic [2:0]            d_neg;
        logic [2:0][DiffW-1:0] dv;
        logic [LenW-1:0]       len;
    } div_side_t;

endpackage

// ===== src/damped_spring_force_top.sv =====
// top level of the damped spring force pipeline
//
// Computes the force on mass A of a damped spring between two point masses.
// item channel: one beat carries both positions and velocities (item_t).
// result channel: one beat per item, in order, with the saturated force and
// the zero_length and clipped flags (result_t).
// cfg channel: cfg_index selects stiffness, damping or rest length; the low
// 31 bits of cfg_data are stored, other indexes are ignored. cfg_ready is
// always high; write only while no item is in flight.
// The pipeline has 4 front stages, 34 square root stages (one length bit
// each), 31 divider stages (one unit vector bit each) and 13 product and
// saturation stages. Throughput is one item per cycle while the receiver
// does not stall; every stage holds a valid bit.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and item_ready drops; no beat is lost or repeated.
// Reset empties the pipeline and loads the register defaults
// (stiffness 1.0, damping 0, rest length 1.0).
module damped_spring_force_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  dsf_pkg::item_t                 item,
    output logic                           result_valid,
    input  logic                           result_ready,
    output dsf_pkg::result_t               result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dsf_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [dsf_pkg::CfgDataW-1:0]   cfg_data
);
    import dsf_pkg::*;

    logic en;
    assign en         = ~result_valid | result_ready;
    assign item_ready = en;
    assign cfg_ready  = 1'b1;

    // configuration registers
    logic [CfgW-1:0] stiff_reg, damp_reg, rest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= STIFFNESS_RESET;
            damp_reg  <= DAMPING_RESET;
            rest_reg  <= REST_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STIFFNESS: stiff_reg <= cfg_data[CfgW-1:0];
                REG_DAMPING:   damp_reg  <= cfg_data[CfgW-1:0];
                REG_REST_LEN:  rest_reg  <= cfg_data[CfgW-1:0];
                default:       ;
            endcase
        end
    end

    // stage 0: differences
    logic [2:0][CoordW-1:0] pa, pb, va, vb;
    logic [2:0][DiffW-1:0]  d0_next, dv0_next;
    logic [2:0][DiffW-1:0]  d0_reg, dv0_reg;
    logic                   v0_reg, v1_reg, v2_reg, v3_reg;

    assign pa = {item.pos_a_z, item.pos_a_y, item.pos_a_x};
    assign pb = {item.pos_b_z, item.pos_b_y, item.pos_b_x};
    assign va = {item.vel_a_z, item.vel_a_y, item.vel_a_x};
    assign vb = {item.vel_b_z, item.vel_b_y, item.vel_b_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d0_next[i]  = {pb[i][CoordW-1], pb[i]} - {pa[i][CoordW-1], pa[i]};
            dv0_next[i] = {vb[i][CoordW-1], vb[i]} - {va[i][CoordW-1], va[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= item_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: magnitudes, stage 2: squares, stage 3: sum of squares
    sqrt_side_t           side1_next, side1_reg, side2_reg, side3_reg;
    logic [2:0][SqW-1:0]  sq2_reg;
    logic [SqW-1:0]       sum3_reg;

    always_comb
    begin
        side1_next.dv = dv0_reg;
        for (int i = 0; i < 3; i++)
        begin
            side1_next.d_neg[i] = d0_reg[i][DiffW-1];
            side1_next.d_mag[i] = d0_reg[i][DiffW-1] ? (~d0_reg[i] + 1'b1) : d0_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg    <= d0_next;
            dv0_reg   <= dv0_next;
            side1_reg <= side1_next;
            for (int i = 0; i < 3; i++)
            begin
                sq2_reg[i] <= SqW'(side1_reg.d_mag[i]) * SqW'(side1_reg.d_mag[i]);
            end
            side2_reg <= side1_reg;
            sum3_reg  <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg <= side2_reg;
        end
    end

    // length
    logic            sq_valid;
    logic [LenW-1:0] len;
    sqrt_side_t      sq_side;

    dsf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (RadW'(sum3_reg)),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .root      (len),
        .out_side  (sq_side)
    );

    // unit vector
    div_side_t             div_in_side, div_side;
    logic                  div_valid;
    logic [2:0][QuotW-1:0] quot;

    assign div_in_side.d_neg = sq_side.d_neg;
    assign div_in_side.dv    = sq_side.dv;
    assign div_in_side.len   = len;

    dsf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_side   (div_in_side),
        .d_mag     (sq_side.d_mag),
        .out_valid (div_valid),
        .out_side  (div_side),
        .quot      (quot)
    );

    dsf_force u_force (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (div_valid),
        .in_side          (div_side),
        .quot             (quot),
        .spring_stiffness (stiff_reg),
        .damping_gain     (damp_reg),
        .rest_length      (rest_reg),
        .out_valid        (result_valid),
        .result           (result)
    );

endmodule

// ===== src/dsf_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module dsf_sqrt (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [dsf_pkg::RadW-1:0] radicand,
    input  dsf_pkg::sqrt_side_t    in_side,
    output logic                   out_valid,
    output logic [dsf_pkg::LenW-1:0] root,
    output dsf_pkg::sqrt_side_t    out_side
);
    import dsf_pkg::*;

    localparam int Steps = RadW / 2;

    logic            v_reg    [Steps];
    logic [RadW-1:0] rad_reg  [Steps];
    logic [RemW-1:0] rem_reg  [Steps];
    logic [LenW-1:0] root_reg [Steps];
    sqrt_side_t      side_reg [Steps];

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic            v_prev;
        logic [RadW-1:0] rad_prev;
        logic [RemW-1:0] rem_prev;
        logic [LenW-1:0] root_prev;
        sqrt_side_t      side_prev;
        logic [RemW+1:0] rem_sh;
        logic [RemW+1:0] trial;
        logic            fit;
        logic [RemW-1:0] rem_next;
        logic [LenW-1:0] root_next;

        if (s == 0) begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = radicand;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign v_prev    = v_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign rem_sh    = {rem_prev, rad_prev[RadW-1 -: 2]};
        assign trial     = (RemW+2)'({root_prev, 2'b01});
        assign fit       = (rem_sh >= trial);
        assign rem_next  = fit ? RemW'(rem_sh - trial) : RemW'(rem_sh);
        assign root_next = {root_prev[LenW-2:0], fit};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= root_next;
                side_reg[s] <= side_prev;
            end
        end

        if (s < Steps - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s] <= rad_prev << 2;
                    rem_reg[s] <= rem_next;
                end
            end
        end
    end

    assign out_valid = v_reg[Steps-1];
    assign root      = root_reg[Steps-1];
    assign out_side  = side_reg[Steps-1];

endmodule

// ===== src/dsf_div.sv =====
// three-lane pipelined restoring divider for the unit vector, one quotient bit per stage
module dsf_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  dsf_pkg::div_side_t                   in_side,
    input  logic [2:0][dsf_pkg::DiffW-1:0]       d_mag,
    output logic                                 out_valid,
    output dsf_pkg::div_side_t                   out_side,
    output logic [2:0][dsf_pkg::QuotW-1:0]       quot
);
    import dsf_pkg::*;

    localparam int Steps = QuotW;

    logic             v_reg    [Steps];
    div_side_t        side_reg [Steps];
    logic [LenW-1:0]  rem_reg  [3][Steps];
    logic [QuotW-1:0] q_reg    [3][Steps];

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic      v_prev;
        div_side_t side_prev;

        if (s == 0) begin : g_first
            assign v_prev    = in_valid;
            assign side_prev = in_side;
        end
        else begin : g_rest
            assign v_prev    = v_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= side_prev;
            end
        end

        for (genvar ln = 0; ln < 3; ln++) begin : g_lane
            logic [LenW-1:0]  rem_prev;
            logic             bit_in;
            logic [QuotW-1:0] q_prev;
            logic [LenW:0]    rem_sh;
            logic [LenW:0]    dvs;
            logic             fit;
            logic [LenW-1:0]  rem_next;

            // dividend is d_mag * 2^30; its top bits already sit below the length
            if (s == 0) begin : g_first
                assign rem_prev = LenW'(d_mag[ln][DiffW-1:1]);
                assign bit_in   = d_mag[ln][0];
                assign q_prev   = '0;
            end
            else begin : g_rest
                assign rem_prev = rem_reg[ln][s-1];
                assign bit_in   = 1'b0;
                assign q_prev   = q_reg[ln][s-1];
            end

            assign rem_sh   = {rem_prev, bit_in};
            assign dvs      = (LenW+1)'(side_prev.len);
            assign fit      = (rem_sh >= dvs);
            assign rem_next = fit ? LenW'(rem_sh - dvs) : LenW'(rem_sh);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[ln][s] <= {q_prev[QuotW-2:0], fit};
                end
            end

            if (s < Steps - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[ln][s] <= rem_next;
                    end
                end
            end
        end
    end

    for (genvar ln = 0; ln < 3; ln++) begin : g_quot
        assign quot[ln] = q_reg[ln][Steps-1];
    end

    assign out_valid = v_reg[Steps-1];
    assign out_side  = side_reg[Steps-1];

endmodule

// ===== src/dsf_force.sv =====
// pipelined spring, damping and force products with output saturation
module dsf_force (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  dsf_pkg::div_side_t             in_side,
    input  logic [2:0][dsf_pkg::QuotW-1:0] quot,
    input  logic [dsf_pkg::CfgW-1:0]       spring_stiffness,
    input  logic [dsf_pkg::CfgW-1:0]       damping_gain,
    input  logic [dsf_pkg::CfgW-1:0]       rest_length,
    output logic                           out_valid,
    output dsf_pkg::result_t               result
);
    import dsf_pkg::*;

    localparam int Stages  = 13;
    localparam int Carries = 12;
    localparam int SplitK  = 17;
    localparam int SplitT  = 26;

    typedef struct packed {
        logic                  zero;
        logic [2:0]            u_neg;
        logic [2:0][QuotW-1:0] u_mag;
    } carry_t;

    logic   v_reg  [Stages];
    carry_t cr_reg [Carries];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < Stages; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < Stages; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    carry_t cr_next;
    assign cr_next.zero  = (in_side.len == '0);
    assign cr_next.u_neg = in_side.d_neg;
    assign cr_next.u_mag = quot;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cr_reg[0] <= cr_next;
            for (int s = 1; s < Carries; s++)
            begin
                cr_reg[s] <= cr_reg[s-1];
            end
        end
    end

    // stage 0: velocity difference and length error in sign-magnitude form
    logic [2:0][DiffW-1:0] dvmag0_next, dvmag0_reg;
    logic [2:0]            dvneg0_next, dvneg0_reg;
    logic [LenW+1:0]       diff_full;
    logic [LenW+1:0]       diff_inv;
    logic [LenW-1:0]       diffmag0_next, diffmag0_reg;
    logic                  diffneg0_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dvneg0_next[i] = in_side.dv[i][DiffW-1];
            dvmag0_next[i] = dvneg0_next[i] ? (~in_side.dv[i] + 1'b1) : in_side.dv[i];
        end
    end

    assign diff_full     = (LenW+2)'(in_side.len) - (LenW+2)'(rest_length);
    assign diff_inv      = ~diff_full + 1'b1;
    assign diffmag0_next = diff_full[LenW+1] ? diff_inv[LenW-1:0] : diff_full[LenW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvmag0_reg   <= dvmag0_next;
            dvneg0_reg   <= dvneg0_next;
            diffmag0_reg <= diffmag0_next;
            diffneg0_reg <= diff_full[LenW+1];
        end
    end

    // stage 1: velocity-by-direction products and split spring product
    logic [2:0][63:0] pdmag1_reg;
    logic [2:0]       pdneg1_reg;
    logic [47:0]      splo1_reg, sphi1_reg;
    logic             sneg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pdmag1_reg[i] <= 64'(dvmag0_reg[i]) * 64'(cr_reg[0].u_mag[i]);
                pdneg1_reg[i] <= dvneg0_reg[i] ^ cr_reg[0].u_neg[i];
            end
            splo1_reg <= 48'(spring_stiffness) * 48'(diffmag0_reg[SplitK-1:0]);
            sphi1_reg <= 48'(spring_stiffness) * 48'(diffmag0_reg[LenW-1:SplitK]);
            sneg1_reg <= diffneg0_reg;
        end
    end

    // stage 2: truncate the dot product terms, join the spring halves
    logic [2:0][33:0] tm2_reg;
    logic [2:0]       tn2_reg;
    logic [64:0]      sp_sum;
    logic [48:0]      smag2_reg;
    logic             sneg2_reg;

    assign sp_sum = {sphi1_reg, {SplitK{1'b0}}} + 65'(splo1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                tm2_reg[i] <= pdmag1_reg[i][63:30];
            end
            tn2_reg   <= pdneg1_reg;
            smag2_reg <= sp_sum[64:16];
            sneg2_reg <= sneg1_reg;
        end
    end

    // stage 3: dot product sum and signed spring term
    logic [2:0][35:0] term3;
    logic [35:0]      dsum3_next, dsum3_reg;
    logic [49:0]      s3_next;
    logic [49:0]      s_reg [3:7];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term3[i] = tn2_reg[i] ? -36'(tm2_reg[i]) : 36'(tm2_reg[i]);
        end
        dsum3_next = term3[0] + term3[1] + term3[2];
        s3_next    = sneg2_reg ? -50'(smag2_reg) : 50'(smag2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dsum3_reg <= dsum3_next;
            s_reg[3]  <= s3_next;
            for (int s = 4; s <= 7; s++)
            begin
                s_reg[s] <= s_reg[s-1];
            end
        end
    end

    // stage 4: magnitude of the dot product
    logic [35:0] dsum_inv;
    logic [34:0] dmag4_reg;
    logic        dneg_reg [4:6];

    assign dsum_inv = ~dsum3_reg + 1'b1;

    // stages 5 and 6: damping product in two halves, then joined
    logic [47:0] cplo5_reg;
    logic [48:0] cphi5_reg;
    logic [65:0] cp_sum;
    logic [49:0] cmag6_reg;

    assign cp_sum = {cphi5_reg, {SplitK{1'b0}}} + 66'(cplo5_reg);

    // stage 7: signed damping term
    logic [50:0] c7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag4_reg   <= dsum3_reg[35] ? dsum_inv[34:0] : dsum3_reg[34:0];
            dneg_reg[4] <= dsum3_reg[35];
            cplo5_reg   <= 48'(damping_gain) * 48'(dmag4_reg[SplitK-1:0]);
            cphi5_reg   <= 49'(damping_gain) * 49'(dmag4_reg[34:SplitK]);
            dneg_reg[5] <= dneg_reg[4];
            cmag6_reg   <= cp_sum[65:16];
            dneg_reg[6] <= dneg_reg[5];
            c7_reg      <= dneg_reg[6] ? -51'(cmag6_reg) : 51'(cmag6_reg);
        end
    end

    // stages 8 and 9: total scalar force and its magnitude
    logic [51:0] t8_reg;
    logic [51:0] t_inv;
    logic [50:0] tmag9_reg;
    logic        tneg9_reg;

    assign t_inv = ~t8_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t8_reg    <= {{2{s_reg[7][49]}}, s_reg[7]} + {c7_reg[50], c7_reg};
            tmag9_reg <= t8_reg[51] ? t_inv[50:0] : t8_reg[50:0];
            tneg9_reg <= t8_reg[51];
        end
    end

    // stages 10 and 11: direction times scalar, split and joined
    logic [2:0][56:0] fplo10_reg;
    logic [2:0][55:0] fphi10_reg;
    logic [2:0]       fneg_reg [10:11];
    logic [2:0][81:0] f_sum;
    logic [2:0][51:0] fmag11_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            f_sum[i] = {fphi10_reg[i], {SplitT{1'b0}}} + 82'(fplo10_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fplo10_reg[i]   <= 57'(cr_reg[9].u_mag[i]) * 57'(tmag9_reg[SplitT-1:0]);
                fphi10_reg[i]   <= 56'(cr_reg[9].u_mag[i]) * 56'(tmag9_reg[50:SplitT]);
                fneg_reg[10][i] <= cr_reg[9].u_neg[i] ^ tneg9_reg;
                fmag11_reg[i]   <= f_sum[i][81:30];
            end
            fneg_reg[11] <= fneg_reg[10];
        end
    end

    // stage 12: saturate to 32 bits, coincident masses give zero
    logic [2:0][CoordW-1:0] fval;
    logic [2:0]             fclip;
    result_t                res_next, res_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fclip[i] = 1'b0;
            if (fneg_reg[11][i])
            begin
                if (fmag11_reg[i] > 52'h0_0000_8000_0000)
                begin
                    fclip[i] = 1'b1;
                    fval[i]  = 32'h8000_0000;
                end
                else
                begin
                    fval[i] = ~fmag11_reg[i][CoordW-1:0] + 32'd1;
                end
            end
            else if (fmag11_reg[i] > 52'h0_0000_7FFF_FFFF)
            begin
                fclip[i] = 1'b1;
                fval[i]  = 32'h7FFF_FFFF;
            end
            else
            begin
                fval[i] = fmag11_reg[i][CoordW-1:0];
            end
        end

        if (cr_reg[11].zero)
        begin
            res_next.force_x     = '0;
            res_next.force_y     = '0;
            res_next.force_z     = '0;
            res_next.zero_length = 1'b1;
            res_next.clipped     = 1'b0;
        end
        else
        begin
            res_next.force_x     = fval[0];
            res_next.force_y     = fval[1];
            res_next.force_z     = fval[2];
            res_next.zero_length = 1'b0;
            res_next.clipped     = |fclip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[Stages-1];
    assign result    = res_reg;

endmodule

// ===== verif/damped_spring_force_top_test.sv =====
// testbench for the damped spring force pipeline: directed, register and random tests
module damped_spring_force_top_test;
    import dsf_pkg::*;

    localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 100;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    item_t item;
    logic result_valid;
    logic result_ready;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    logic [CfgW-1:0] stiffness;
    logic [CfgW-1:0] damping;
    logic [CfgW-1:0] rest_len;

    result_t force_queue[$];
    int mismatches;
    bit calm;

    damped_spring_force_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_ready(item_ready),
        .item(item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [127:0] mag(logic signed [127:0] a);
        return a < 0 ? -a : a;
    endfunction

    // signed product scaled down, truncated toward zero
    function automatic logic signed [127:0] scaled_mul(logic signed [127:0] a,
                                                       logic signed [127:0] b, int sh);
        logic signed [127:0] m;
        m = (mag(a) * mag(b)) >>> sh;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic result_t spring_force(item_t it);
        logic signed [31:0] pa[3];
        logic signed [31:0] pb[3];
        logic signed [31:0] va[3];
        logic signed [31:0] vb[3];
        logic signed [127:0] d[3];
        logic signed [127:0] dv[3];
        logic signed [127:0] u[3];
        logic signed [127:0] f[3];
        logic signed [127:0] spring;
        logic signed [127:0] rate;
        logic signed [127:0] total;
        logic [127:0] sq;
        logic [127:0] len;
        logic [127:0] trial;
        result_t r;
        pa = '{it.pos_a_x, it.pos_a_y, it.pos_a_z};
        pb = '{it.pos_b_x, it.pos_b_y, it.pos_b_z};
        va = '{it.vel_a_x, it.vel_a_y, it.vel_a_z};
        vb = '{it.vel_b_x, it.vel_b_y, it.vel_b_z};
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = pb[i];
            d[i] = d[i] - pa[i];
            dv[i] = vb[i];
            dv[i] = dv[i] - va[i];
            sq = sq + mag(d[i]) * mag(d[i]);
        end
        len = '0;
        for (int b = 34; b >= 0; b--)
        begin
            trial = len | (128'd1 << b);
            if (trial * trial <= sq)
                len = trial;
        end
        r = '0;
        if (len == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            u[i] = (mag(d[i]) << 30) / len;
            if (d[i] < 0)
                u[i] = -u[i];
        end
        spring = scaled_mul($signed({97'd0, stiffness}),
                            $signed(len) - $signed({97'd0, rest_len}), 16);
        rate = '0;
        for (int i = 0; i < 3; i++)
            rate = rate + scaled_mul(dv[i], u[i], 30);
        total = spring + scaled_mul($signed({97'd0, damping}), rate, 16);
        for (int i = 0; i < 3; i++)
        begin
            f[i] = scaled_mul(u[i], total, 30);
            if (f[i] > 128'sd2147483647)
            begin
                f[i] = 128'sd2147483647;
                r.clipped = 1'b1;
            end
            if (f[i] < -128'sd2147483648)
            begin
                f[i] = -128'sd2147483648;
                r.clipped = 1'b1;
            end
        end
        r.force_x = f[0][31:0];
        r.force_y = f[1][31:0];
        r.force_z = f[2][31:0];
        return r;
    endfunction

    task automatic send_item(item_t it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        force_queue.push_back(spring_force(it));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (force_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
        drain();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_STIFFNESS: stiffness = data[CfgW-1:0];
            REG_DAMPING:   damping = data[CfgW-1:0];
            REG_REST_LEN:  rest_len = data[CfgW-1:0];
            default: ;
        endcase
    endtask

    function automatic item_t random_item(bit near);
        item_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        // keep masses within a few units so the spring term stays in range
        if (near)
        begin
            it.pos_b_x = it.pos_a_x + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            it.pos_b_y = it.pos_a_y + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            it.pos_b_z = it.pos_a_z + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            it.vel_b_x = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            it.vel_a_y = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        end
        return it;
    endfunction

    task automatic test_directed();
        item_t it;
        it = '0;
        send_item(it);                              // coincident masses
        it.pos_a_x = 32'sh7fffffff;
        it.pos_b_x = 32'sh7fffffff;
        send_item(it);
        it = '0;
        it.pos_b_x = 32'sh00010000;                 // one unit apart, the default rest length
        send_item(it);
        it.pos_b_x = 32'sh00000001;                 // smallest separation
        send_item(it);
        it = '0;
        it.pos_b_y = 32'sh00030000;
        it.vel_b_y = 32'sh00020000;
        it.vel_a_y = 32'shfffe0000;
        send_item(it);
        for (int s = 0; s < 2; s++)
        begin
            it = '0;
            it.pos_a_x = s ? 32'sh80000000 : 32'sh7fffffff;
            it.pos_a_y = s ? 32'sh80000000 : 32'sh7fffffff;
            it.pos_a_z = s ? 32'sh80000000 : 32'sh7fffffff;
            it.pos_b_x = s ? 32'sh7fffffff : 32'sh80000000;
            it.pos_b_y = s ? 32'sh7fffffff : 32'sh80000000;
            it.pos_b_z = s ? 32'sh7fffffff : 32'sh80000000;
            it.vel_a_x = s ? 32'sh80000000 : 32'sh7fffffff;
            it.vel_a_y = s ? 32'sh80000000 : 32'sh7fffffff;
            it.vel_a_z = s ? 32'sh80000000 : 32'sh7fffffff;
            it.vel_b_x = s ? 32'sh7fffffff : 32'sh80000000;
            it.vel_b_y = s ? 32'sh7fffffff : 32'sh80000000;
            it.vel_b_z = s ? 32'sh7fffffff : 32'sh80000000;
            send_item(it);
        end
        it = '0;
        it.pos_b_z = 32'sh80000000;
        send_item(it);
        it = '1;
        send_item(it);
    endtask

    task automatic test_extreme_regs();
        write_reg(REG_STIFFNESS, 32'hffffffff);     // top bit dropped
        write_reg(REG_DAMPING, 32'h7fffffff);
        write_reg(REG_REST_LEN, 32'h0);
        test_directed();
        write_reg(REG_UNUSED, 32'h12345678);
        write_reg(REG_REST_LEN, 32'h7fffffff);
        write_reg(REG_DAMPING, 32'h0);
        test_directed();
        write_reg(REG_STIFFNESS, 32'h0);
        write_reg(REG_DAMPING, 32'h80010000);
        write_reg(REG_REST_LEN, 32'h00020000);
        test_directed();
    endtask

    task automatic test_random(int count);
        for (int p = 0; p < 5; p++)
        begin
            write_reg(REG_STIFFNESS, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20));
            write_reg(REG_DAMPING, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
            write_reg(REG_REST_LEN, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18));
            for (int n = 0; n < count / 5; n++)
            begin
                if (n % 100 == 0)
                    calm = $urandom_range(0, 3) == 0;
                if (n == count / 10)
                    drain();
                send_item(random_item($urandom_range(0, 2) != 0));
            end
        end
    endtask

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            int stall;
            stall = calm ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            if (force_queue.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                result_t want;
                want = force_queue.pop_front();
                if (result.force_x !== want.force_x)
                begin
                    $error("force_x expected %0d got %0d", want.force_x, result.force_x);
                    mismatches++;
                end
                if (result.force_y !== want.force_y)
                begin
                    $error("force_y expected %0d got %0d", want.force_y, result.force_y);
                    mismatches++;
                end
                if (result.force_z !== want.force_z)
                begin
                    $error("force_z expected %0d got %0d", want.force_z, result.force_z);
                    mismatches++;
                end
                if (result.zero_length !== want.zero_length)
                begin
                    $error("zero_length expected %0b got %0b", want.zero_length,
                           result.zero_length);
                    mismatches++;
                end
                if (result.clipped !== want.clipped)
                begin
                    $error("clipped expected %0b got %0b", want.clipped, result.clipped);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[damped_spring_force_top] ERROR");
        $finish;
    end

    initial
    begin
        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stiffness = STIFFNESS_RESET;
        damping = DAMPING_RESET;
        rest_len = REST_LEN_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_extreme_regs();
        test_random(1600);
        drain();
        if (mismatches == 0)
            $display("[damped_spring_force_top] OK");
        else
            $display("[damped_spring_force_top] ERROR");
        $finish;
    end
endmodule
